[hw/rtl/mcb_pkg.sv]
// ----------------------------------------------------------------------------
// mcb_pkg
// Shared types and constants for the multi-channel LED blinker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcb_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int TIME_BITS_DEF    = 16;

  localparam int UNIT_W = 4;
  localparam int TICKS_W = 16;
  localparam int OUT_W  = 4;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  typedef struct packed {
    logic              tick;
    logic              set;
    logic [UNIT_W-1:0] unit;
  } chan_cmd_t;

  typedef struct packed {
    logic armed;
    logic drive_lit;
  } chan_status_t;

endpackage

[hw/rtl/multi_channel_led_blinker_top.sv]
// ----------------------------------------------------------------------------
// multi_channel_led_blinker_top
// Datapath: the input register feeds the result register; one item accepted
//   per cycle unless out_stall holds a result, all channels in parallel.
// Input stalls only while a held result is stalled by out_stall.
// Reset: synchronous, all channels disarmed and dark, active_high set to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_channel_led_blinker_top #(
  parameter int NUM_CHANNELS = mcb_pkg::NUM_CHANNELS_DEF,
  parameter int TIME_BITS    = mcb_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        op,
  input  logic [mcb_pkg::UNIT_W-1:0]  unit,
  input  logic [mcb_pkg::TICKS_W-1:0] lit_ticks,
  input  logic [mcb_pkg::TICKS_W-1:0] dark_ticks,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mcb_pkg::OUT_W-1:0]   pin_levels,
  output logic [mcb_pkg::OUT_W-1:0]   armed_mask,
  input  logic                        wr_en,
  input  logic                        wr_data
);
  import mcb_pkg::*;

  logic                active_high;
  logic                in_full;
  logic                op_q;
  logic [UNIT_W-1:0]   unit_q;
  logic [TICKS_W-1:0]  lit_q;
  logic [TICKS_W-1:0]  dark_q;
  logic                accept;
  logic                advance;
  chan_cmd_t           cmd;
  chan_status_t        status [NUM_CHANNELS];
  logic [OUT_W-1:0]    pins_next;
  logic [OUT_W-1:0]    mask_next;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  assign cmd.tick = advance && (op_q == OP_TICK);
  assign cmd.set  = advance && (op_q == OP_SET);
  assign cmd.unit = unit_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_high <= 1'b1;
    end else if (wr_en) begin
      active_high <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op;
      unit_q <= unit;
      lit_q  <= lit_ticks;
      dark_q <= dark_ticks;
    end
  end

  for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_chan
    mcb_chan #(
      .CH_INDEX  (ch),
      .TIME_BITS (TIME_BITS)
    ) u_chan (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .lit_in      (TIME_BITS'(lit_q)),
      .dark_in     (TIME_BITS'(dark_q)),
      .status_next (status[ch])
    );
  end

  for (genvar b = 0; b < OUT_W; b++) begin : g_out
    if (b < NUM_CHANNELS) begin : g_used
      assign pins_next[b] = status[b].drive_lit ^ !active_high;
      assign mask_next[b] = status[b].armed;
    end else begin : g_unused
      assign pins_next[b] = 1'b0;
      assign mask_next[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pin_levels <= pins_next;
      armed_mask <= mask_next;
    end
  end

endmodule

[hw/rtl/mcb_chan.sv]
// ----------------------------------------------------------------------------
// mcb_chan
// One blink channel: timing registers, phase, countdown and drive level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcb_chan #(
  parameter int CH_INDEX  = 0,
  parameter int TIME_BITS = mcb_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mcb_pkg::chan_cmd_t   cmd,
  input  logic [TIME_BITS-1:0] lit_in,
  input  logic [TIME_BITS-1:0] dark_in,
  output mcb_pkg::chan_status_t status_next
);
  import mcb_pkg::*;

  logic                 armed, armed_next;
  logic                 phase_lit, phase_lit_next;
  logic                 drive_lit, drive_lit_next;
  logic [TIME_BITS-1:0] lit_dur, lit_dur_next;
  logic [TIME_BITS-1:0] dark_dur, dark_dur_next;
  logic [TIME_BITS-1:0] countdown, countdown_next;

  logic                 hit;
  logic [TIME_BITS-1:0] new_dur;
  logic [TIME_BITS-1:0] cd_mid;

  assign hit     = cmd.set && (cmd.unit == UNIT_W'(CH_INDEX));
  assign new_dur = phase_lit ? dark_dur : lit_dur;

  always_comb begin
    armed_next     = armed;
    phase_lit_next = phase_lit;
    drive_lit_next = drive_lit;
    lit_dur_next   = lit_dur;
    dark_dur_next  = dark_dur;
    countdown_next = countdown;
    cd_mid         = countdown;
    if (hit) begin
      if (lit_in != '0 || dark_in != '0) begin
        if (!armed) begin
          armed_next     = 1'b1;
          countdown_next = '0;
          phase_lit_next = 1'b0;
        end
        lit_dur_next  = lit_in;
        dark_dur_next = dark_in;
      end else begin
        armed_next     = 1'b0;
        lit_dur_next   = '0;
        dark_dur_next  = '0;
        countdown_next = '0;
        phase_lit_next = 1'b0;
        drive_lit_next = 1'b0;
      end
    end else if (cmd.tick && armed) begin
      if (countdown == '0) begin
        phase_lit_next = !phase_lit;
        if (new_dur != '0) begin
          cd_mid         = new_dur;
          drive_lit_next = !phase_lit;
        end
      end
      countdown_next = (cd_mid != '0) ? cd_mid - TIME_BITS'(1) : cd_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= 1'b0;
      phase_lit <= 1'b0;
      drive_lit <= 1'b0;
      lit_dur   <= '0;
      dark_dur  <= '0;
      countdown <= '0;
    end else begin
      armed     <= armed_next;
      phase_lit <= phase_lit_next;
      drive_lit <= drive_lit_next;
      lit_dur   <= lit_dur_next;
      dark_dur  <= dark_dur_next;
      countdown <= countdown_next;
    end
  end

  assign status_next.armed     = armed_next;
  assign status_next.drive_lit = drive_lit_next;

endmodule
